FILE: rtl/psq_pkg.sv
// Shared types and codes for the priority spill triple queue.
`timescale 1ns / 1ps
`default_nettype none
package psq_pkg;

    localparam int FIELD_W = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] QUEUE_A = 2'd0;
    localparam logic [1:0] QUEUE_B = 2'd1;
    localparam logic [1:0] QUEUE_C = 2'd2;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_POP
    } fsm_state_t;

    typedef struct packed {
        logic                      op;
        logic [1:0]                queue_sel;
        logic signed [FIELD_W-1:0] data_in;
    } request_t;

    typedef struct packed {
        status_t                   status;
        logic [1:0]                queue_used;
        logic signed [FIELD_W-1:0] data_out;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic pop_finish;
    } cmd_t;

    typedef struct packed {
        logic pop_hit;
    } stat_t;

endpackage
`default_nettype wire

FILE: rtl/psq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module psq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/psq_ctrl.sv
// Controller state machine: accepts requests and sequences the pop read.
`timescale 1ns / 1ps
`default_nettype none
module psq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          op,
    input  wire psq_pkg::stat_t stat,
    output psq_pkg::cmd_t      cmd,
    output logic               busy
);
    import psq_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start && op == OP_POP && stat.pop_hit)
                begin
                    state_next = FSM_POP;
                end
            end
            FSM_POP:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                cmd.push = start && op == OP_PUSH;
                cmd.pop  = start && op == OP_POP;
            end
            FSM_POP:
            begin
                cmd.pop_finish = 1'b1;
                busy           = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/psq_datapath.sv
// Datapath: three queue stores, their pointers and counts, and the result register.
`timescale 1ns / 1ps
`default_nettype none
module psq_datapath #(
    parameter int DEPTH_A    = 16,
    parameter int DEPTH_B    = 16,
    parameter int DEPTH_C    = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire psq_pkg::cmd_t     cmd,
    input  wire psq_pkg::request_t request,
    output psq_pkg::stat_t         stat,
    output logic                   done,
    output psq_pkg::result_t       result
);
    import psq_pkg::*;

    localparam int AW_A = $clog2(DEPTH_A);
    localparam int AW_B = $clog2(DEPTH_B);
    localparam int AW_C = $clog2(DEPTH_C);
    localparam int CW_A = $clog2(DEPTH_A + 1);
    localparam int CW_B = $clog2(DEPTH_B + 1);
    localparam int CW_C = $clog2(DEPTH_C + 1);

    localparam logic [AW_A-1:0] LAST_A = AW_A'(DEPTH_A - 1);
    localparam logic [AW_B-1:0] LAST_B = AW_B'(DEPTH_B - 1);
    localparam logic [AW_C-1:0] LAST_C = AW_C'(DEPTH_C - 1);
    localparam logic [CW_A-1:0] FULL_A = CW_A'(DEPTH_A);
    localparam logic [CW_B-1:0] FULL_B = CW_B'(DEPTH_B);
    localparam logic [CW_C-1:0] FULL_C = CW_C'(DEPTH_C);

    logic [AW_A-1:0] write_ptr_a_reg, write_ptr_a_next, read_ptr_a_reg, read_ptr_a_next;
    logic [AW_B-1:0] write_ptr_b_reg, write_ptr_b_next, read_ptr_b_reg, read_ptr_b_next;
    logic [AW_C-1:0] write_ptr_c_reg, write_ptr_c_next, read_ptr_c_reg, read_ptr_c_next;
    logic [CW_A-1:0] count_a_reg, count_a_next;
    logic [CW_B-1:0] count_b_reg, count_b_next;
    logic [CW_C-1:0] count_c_reg, count_c_next;
    logic [1:0]      pop_queue_reg, pop_queue_next;
    logic            done_reg, done_next;
    result_t         result_reg, result_next;

    logic                  we_a, we_b, we_c, re_a, re_b, re_c;
    logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b, rdata_c, rdata_sel;
    logic                  full_a, full_b, full_c, hit;

    assign wdata  = DATA_WIDTH'($unsigned(request.data_in));
    assign full_a = count_a_reg == FULL_A;
    assign full_b = count_b_reg == FULL_B;
    assign full_c = count_c_reg == FULL_C;

    always_comb
    begin
        case (request.queue_sel)
            QUEUE_A: hit = count_a_reg != '0;
            QUEUE_B: hit = count_b_reg != '0;
            QUEUE_C: hit = count_c_reg != '0;
            default: hit = 1'b0;
        endcase
    end

    assign stat.pop_hit = hit;

    always_comb
    begin
        case (pop_queue_reg)
            QUEUE_A: rdata_sel = rdata_a;
            QUEUE_B: rdata_sel = rdata_b;
            default: rdata_sel = rdata_c;
        endcase
    end

    always_comb
    begin
        write_ptr_a_next = write_ptr_a_reg;
        write_ptr_b_next = write_ptr_b_reg;
        write_ptr_c_next = write_ptr_c_reg;
        read_ptr_a_next  = read_ptr_a_reg;
        read_ptr_b_next  = read_ptr_b_reg;
        read_ptr_c_next  = read_ptr_c_reg;
        count_a_next     = count_a_reg;
        count_b_next     = count_b_reg;
        count_c_next     = count_c_reg;
        pop_queue_next   = pop_queue_reg;
        result_next      = result_reg;
        done_next        = 1'b0;
        we_a = 1'b0;
        we_b = 1'b0;
        we_c = 1'b0;
        re_a = 1'b0;
        re_b = 1'b0;
        re_c = 1'b0;

        if (cmd.push)
        begin
            done_next              = 1'b1;
            result_next.status     = ST_PUSHED;
            result_next.queue_used = QUEUE_A;
            result_next.data_out   = '0;
            if (!full_c)
            begin
                we_c                   = 1'b1;
                write_ptr_c_next       = (write_ptr_c_reg == LAST_C) ? '0 : write_ptr_c_reg + 1'b1;
                count_c_next           = count_c_reg + 1'b1;
                result_next.queue_used = QUEUE_C;
            end
            else if (!full_a)
            begin
                we_a             = 1'b1;
                write_ptr_a_next = (write_ptr_a_reg == LAST_A) ? '0 : write_ptr_a_reg + 1'b1;
                count_a_next     = count_a_reg + 1'b1;
            end
            else if (!full_b)
            begin
                we_b                   = 1'b1;
                write_ptr_b_next       = (write_ptr_b_reg == LAST_B) ? '0 : write_ptr_b_reg + 1'b1;
                count_b_next           = count_b_reg + 1'b1;
                result_next.queue_used = QUEUE_B;
            end
            else
            begin
                result_next.status = ST_FULL;
            end
        end
        else if (cmd.pop)
        begin
            result_next.queue_used = request.queue_sel;
            result_next.data_out   = '0;
            result_next.status     = ST_EMPTY;
            pop_queue_next         = request.queue_sel;
            done_next              = !hit;
            if (hit)
            begin
                case (request.queue_sel)
                    QUEUE_A:
                    begin
                        re_a            = 1'b1;
                        read_ptr_a_next = (read_ptr_a_reg == LAST_A) ? '0 : read_ptr_a_reg + 1'b1;
                        count_a_next    = count_a_reg - 1'b1;
                    end
                    QUEUE_B:
                    begin
                        re_b            = 1'b1;
                        read_ptr_b_next = (read_ptr_b_reg == LAST_B) ? '0 : read_ptr_b_reg + 1'b1;
                        count_b_next    = count_b_reg - 1'b1;
                    end
                    default:
                    begin
                        re_c            = 1'b1;
                        read_ptr_c_next = (read_ptr_c_reg == LAST_C) ? '0 : read_ptr_c_reg + 1'b1;
                        count_c_next    = count_c_reg - 1'b1;
                    end
                endcase
            end
        end
        else if (cmd.pop_finish)
        begin
            done_next            = 1'b1;
            result_next.status   = ST_POPPED;
            result_next.data_out = FIELD_W'(rdata_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_a_reg <= '0;
            write_ptr_b_reg <= '0;
            write_ptr_c_reg <= '0;
            read_ptr_a_reg  <= '0;
            read_ptr_b_reg  <= '0;
            read_ptr_c_reg  <= '0;
            count_a_reg     <= '0;
            count_b_reg     <= '0;
            count_c_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            write_ptr_a_reg <= write_ptr_a_next;
            write_ptr_b_reg <= write_ptr_b_next;
            write_ptr_c_reg <= write_ptr_c_next;
            read_ptr_a_reg  <= read_ptr_a_next;
            read_ptr_b_reg  <= read_ptr_b_next;
            read_ptr_c_reg  <= read_ptr_c_next;
            count_a_reg     <= count_a_next;
            count_b_reg     <= count_b_next;
            count_c_reg     <= count_c_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_queue_reg <= pop_queue_next;
        result_reg    <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    psq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH_A)) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (write_ptr_a_reg),
        .wdata (wdata),
        .re    (re_a),
        .raddr (read_ptr_a_reg),
        .rdata (rdata_a)
    );

    psq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH_B)) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (write_ptr_b_reg),
        .wdata (wdata),
        .re    (re_b),
        .raddr (read_ptr_b_reg),
        .rdata (rdata_b)
    );

    psq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH_C)) u_store_c (
        .clk   (clk),
        .we    (we_c),
        .waddr (write_ptr_c_reg),
        .wdata (wdata),
        .re    (re_c),
        .raddr (read_ptr_c_reg),
        .rdata (rdata_c)
    );

endmodule
`default_nettype wire

FILE: rtl/priority_spill_triple_fifo.sv
// Top level of the priority spill triple queue: controller, datapath and checks.
//
// Three ring-buffer queues, A, B and C, share one push path. A push goes to
// queue C if it has room, otherwise to A, otherwise to B; if all are full the
// request completes with the full status. A pop names one queue and returns
// its oldest word, or the empty status.
// A request is taken at a rising edge where start is high and busy is low.
// Each request gives exactly one result, shown on result for one cycle with
// done high; the receiver cannot hold results off.
// A push, and a pop of an empty or unknown queue, gives its result in the cycle
// after the request and leaves busy low, so one such request fits every cycle.
// A pop that finds data waits for the queue memory read, which is registered,
// so busy stays high for the one cycle in which the read completes.
// Reset clears all pointers and counts, so every queue starts empty; the
// memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module priority_spill_triple_fifo #(
    parameter int DEPTH_A    = 16,
    parameter int DEPTH_B    = 16,
    parameter int DEPTH_C    = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire psq_pkg::request_t request,
    output logic                   busy,
    output logic                   done,
    output psq_pkg::result_t       result
);
    import psq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    psq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (request.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    psq_datapath #(
        .DEPTH_A    (DEPTH_A),
        .DEPTH_B    (DEPTH_B),
        .DEPTH_C    (DEPTH_C),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
        else $error("Pop read wait lasted more than one cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.op == OP_PUSH) |=> (done && result.status != ST_POPPED))
        else $error("Push request did not complete in the next cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_POPPED) |-> $past(busy))
        else $error("Popped result appeared without a read cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_POPPED) |-> result.data_out == '0)
        else $error("Nonzero data on a result that popped nothing.");

endmodule
`default_nettype wire
